// ===== src/spid_pkg.sv =====
// spid_pkg: shared widths, register reset values, command codes and types
// for the servo pid block with deadband and output smoothing.
// No dependencies.
package spid_pkg;

	localparam int DEF_POSITION_WIDTH = 16;
	localparam int DEF_COEFF_FRAC_BITS = 12;

	localparam int GAIN_W = 16;
	localparam int LIMIT_W = 12;
	localparam int ALPHA_W = 13;
	localparam int AMAX_W = 13;
	localparam int ANGLE_W = 14;
	localparam int SUM_W = 13;
	localparam int SMOOTH_W = 27;
	localparam int ADJ_W = 9;
	localparam int POS_FRAC = 4;
	localparam int ALPHA_FRAC = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 13'd4096;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_KP = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ILIM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ALIM = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DEAD = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_AMAX = 3'd7;

	localparam logic [GAIN_W-1:0] RST_KP = 16'd492;
	localparam logic [GAIN_W-1:0] RST_KI = 16'd410;
	localparam logic [GAIN_W-1:0] RST_KD = 16'd901;
	localparam logic [LIMIT_W-1:0] RST_ILIM = 12'd80;
	localparam logic [LIMIT_W-1:0] RST_ALIM = 12'd240;
	localparam logic [ALPHA_W-1:0] RST_ALPHA = 13'd1638;
	localparam logic [LIMIT_W-1:0] RST_DEAD = 12'd48;
	localparam logic [AMAX_W-1:0] RST_AMAX = 13'd5400;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [LIMIT_W-1:0] ilim;
		logic [LIMIT_W-1:0] alim;
		logic [ALPHA_W-1:0] alpha;
		logic [LIMIT_W-1:0] dead;
		logic [AMAX_W-1:0] amax;
	} cfg_t;

	typedef logic [2:0] mul_sel_t;
	localparam mul_sel_t MUL_P = 3'd0;
	localparam mul_sel_t MUL_I = 3'd1;
	localparam mul_sel_t MUL_D = 3'd2;
	localparam mul_sel_t MUL_RAW = 3'd3;
	localparam mul_sel_t MUL_SM = 3'd4;

	typedef logic [2:0] acc_op_t;
	localparam acc_op_t ACC_HOLD = 3'd0;
	localparam acc_op_t ACC_LOAD = 3'd1;
	localparam acc_op_t ACC_ADD = 3'd2;
	localparam acc_op_t ACC_LOAD_SH = 3'd3;
	localparam acc_op_t ACC_CLAMP = 3'd4;

	typedef struct packed {
		logic load_err;
		logic decide;
		mul_sel_t mul_sel;
		acc_op_t acc_op;
		logic adj_en;
		logic raw_en;
		logic seed_en;
		logic smooth_en;
		logic angle_en;
		logic result_load;
	} cmd_t;

endpackage

// ===== src/spid_regs.sv =====
// spid_regs: configuration register file, write only, reset to the tuned defaults.
// Depends on spid_pkg.
module spid_regs
	import spid_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [CFG_INDEX_W-1:0] index,
	input logic [CFG_DATA_W-1:0] data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp <= RST_KP;
			cfg_q.ki <= RST_KI;
			cfg_q.kd <= RST_KD;
			cfg_q.ilim <= RST_ILIM;
			cfg_q.alim <= RST_ALIM;
			cfg_q.alpha <= RST_ALPHA;
			cfg_q.dead <= RST_DEAD;
			cfg_q.amax <= RST_AMAX;
		end else if (wr_en) begin
			unique case (index)
				REG_KP: cfg_q.kp <= data[GAIN_W-1:0];
				REG_KI: cfg_q.ki <= data[GAIN_W-1:0];
				REG_KD: cfg_q.kd <= data[GAIN_W-1:0];
				REG_ILIM: cfg_q.ilim <= data[LIMIT_W-1:0];
				REG_ALIM: cfg_q.alim <= data[LIMIT_W-1:0];
				REG_ALPHA: cfg_q.alpha <= data[ALPHA_W-1:0];
				REG_DEAD: cfg_q.dead <= data[LIMIT_W-1:0];
				REG_AMAX: cfg_q.amax <= data[AMAX_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/spid_ctrl.sv =====
// spid_ctrl: sequencer that steps the datapath through one update per item.
// Depends on spid_pkg.
module spid_ctrl
	import spid_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic inside_band,
	input logic out_free,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_MP = 4'd2;
	localparam logic [3:0] S_MI = 4'd3;
	localparam logic [3:0] S_MD = 4'd4;
	localparam logic [3:0] S_MACC = 4'd5;
	localparam logic [3:0] S_CLAMP = 4'd6;
	localparam logic [3:0] S_TRUNC = 4'd7;
	localparam logic [3:0] S_RAW = 4'd8;
	localparam logic [3:0] S_FA = 4'd9;
	localparam logic [3:0] S_FB = 4'd10;
	localparam logic [3:0] S_FC = 4'd11;
	localparam logic [3:0] S_SM = 4'd12;
	localparam logic [3:0] S_ANG = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_P;
		cmd.acc_op = ACC_HOLD;
		in_ready = 1'b0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_err = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d = inside_band ? S_DONE : S_MP;
			end
			S_MP: begin
				cmd.mul_sel = MUL_P;
				state_d = S_MI;
			end
			// multiplier output is registered, so the product of a select arrives in the next state
			S_MI: begin
				cmd.mul_sel = MUL_I;
				cmd.acc_op = ACC_LOAD;
				state_d = S_MD;
			end
			S_MD: begin
				cmd.mul_sel = MUL_D;
				cmd.acc_op = ACC_ADD;
				state_d = S_MACC;
			end
			S_MACC: begin
				cmd.acc_op = ACC_ADD;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.acc_op = ACC_CLAMP;
				state_d = S_TRUNC;
			end
			S_TRUNC: begin
				cmd.adj_en = 1'b1;
				state_d = S_RAW;
			end
			S_RAW: begin
				cmd.raw_en = 1'b1;
				state_d = S_FA;
			end
			S_FA: begin
				cmd.mul_sel = MUL_RAW;
				cmd.seed_en = 1'b1;
				state_d = S_FB;
			end
			S_FB: begin
				cmd.mul_sel = MUL_SM;
				cmd.acc_op = ACC_LOAD_SH;
				state_d = S_FC;
			end
			S_FC: begin
				cmd.acc_op = ACC_ADD;
				state_d = S_SM;
			end
			S_SM: begin
				cmd.smooth_en = 1'b1;
				state_d = S_ANG;
			end
			S_ANG: begin
				cmd.angle_en = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/spid_dp.sv =====
// spid_dp: datapath with error state, one shared registered multiplier,
// accumulator, clamps and the low-pass filter state. Depends on spid_pkg.
module spid_dp
	import spid_pkg::*;
#(
	parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
	parameter int COEFF_FRACTION_BITS = DEF_COEFF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input cfg_t cfg,
	input logic signed [POSITION_WIDTH-1:0] target_position,
	input logic signed [POSITION_WIDTH-1:0] measured_position,
	output logic inside_band,
	output logic signed [ANGLE_W-1:0] angle,
	output logic at_target
);

	localparam int EW = POSITION_WIDTH + 1;
	localparam int DW = POSITION_WIDTH + 2;
	localparam int MW = (EW > LIMIT_W) ? EW : LIMIT_W;
	localparam int SW = ((DW > SUM_W) ? DW : SUM_W) + 1;
	localparam int BW = (DW > SMOOTH_W) ? DW : SMOOTH_W;
	localparam int PW = GAIN_W + 1 + BW;
	localparam int AW = PW + ALPHA_FRAC + 2;
	localparam int TW = LIMIT_W + COEFF_FRACTION_BITS + 1;
	localparam int TSH = COEFF_FRACTION_BITS + POS_FRAC;
	localparam int RW = ANGLE_W + 1;

	logic signed [EW-1:0] err_q;
	logic signed [EW-1:0] le_q;
	logic signed [SUM_W-1:0] es_q;
	logic signed [DW-1:0] d_q;
	logic at_q;
	logic signed [PW-1:0] prod_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [ADJ_W-1:0] adj_q;
	logic signed [ANGLE_W-1:0] raw_q;
	logic signed [ANGLE_W-1:0] ang_q;
	logic signed [SMOOTH_W-1:0] sm_q;

	logic [EW-1:0] mag;
	logic signed [SW-1:0] es_sum;
	logic signed [SW-1:0] ilim_s;
	logic signed [SUM_W-1:0] es_next;
	logic [ALPHA_W-1:0] alpha_eff;
	logic [ALPHA_W-1:0] alpha_rest;
	logic signed [GAIN_W:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] lim_pos;
	logic signed [AW-1:0] acc_d;
	logic signed [TW-1:0] acc_t;
	logic signed [TW-1:0] adj_bias;
	logic signed [TW-1:0] adj_sum;
	logic signed [TW-1:0] adj_full;
	logic signed [RW-1:0] raw_sum;
	logic signed [RW-1:0] amax_s;
	logic signed [ANGLE_W-1:0] raw_next;
	logic signed [AW-1:0] sm_bias;
	logic signed [AW-1:0] sm_full;
	logic signed [SMOOTH_W-1:0] ang_bias;
	logic signed [SMOOTH_W-1:0] ang_full;

	// deadband test
	assign mag = err_q[EW-1] ? $unsigned(-err_q) : $unsigned(err_q);
	assign inside_band = MW'(mag) < MW'(cfg.dead);

	// integral update with symmetric clamp
	assign es_sum = SW'(es_q) + SW'(err_q);
	assign ilim_s = $signed(SW'(cfg.ilim));
	always_comb begin
		priority if (es_sum > ilim_s) begin
			es_next = SUM_W'(ilim_s);
		end else if (es_sum < -ilim_s) begin
			es_next = SUM_W'(-ilim_s);
		end else begin
			es_next = SUM_W'(es_sum);
		end
	end

	// alpha above one acts as one
	assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
	assign alpha_rest = ALPHA_ONE - alpha_eff;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_P: begin
				mul_a = $signed({1'b0, cfg.kp});
				mul_b = BW'(err_q);
			end
			MUL_I: begin
				mul_a = $signed({1'b0, cfg.ki});
				mul_b = BW'(es_q);
			end
			MUL_D: begin
				mul_a = $signed({1'b0, cfg.kd});
				mul_b = BW'(d_q);
			end
			MUL_RAW: begin
				mul_a = $signed((GAIN_W + 1)'(alpha_eff));
				mul_b = BW'(raw_q);
			end
			MUL_SM: begin
				mul_a = $signed((GAIN_W + 1)'(alpha_rest));
				mul_b = BW'(sm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_ext = AW'(prod_s1);
	assign lim_pos = $signed(AW'({cfg.alim, {COEFF_FRACTION_BITS{1'b0}}}));

	always_comb begin
		unique case (cmd.acc_op)
			ACC_HOLD: acc_d = acc_q;
			ACC_LOAD: acc_d = prod_ext;
			ACC_ADD: acc_d = acc_q + prod_ext;
			ACC_LOAD_SH: acc_d = prod_ext <<< ALPHA_FRAC;
			ACC_CLAMP: begin
				priority if (acc_q > lim_pos) begin
					acc_d = lim_pos;
				end else if (acc_q < -lim_pos) begin
					acc_d = -lim_pos;
				end else begin
					acc_d = acc_q;
				end
			end
			default: acc_d = acc_q;
		endcase
	end

	// truncate toward zero: bias negatives before the arithmetic shift
	assign acc_t = acc_q[TW-1:0];
	assign adj_bias = acc_t[TW-1] ? $signed(TW'({TSH{1'b1}})) : '0;
	assign adj_sum = acc_t + adj_bias;
	assign adj_full = adj_sum >>> TSH;

	assign raw_sum = RW'(ang_q) + RW'(adj_q);
	assign amax_s = $signed(RW'(cfg.amax));
	always_comb begin
		priority if (raw_sum > amax_s) begin
			raw_next = ANGLE_W'(amax_s);
		end else if (raw_sum < -amax_s) begin
			raw_next = ANGLE_W'(-amax_s);
		end else begin
			raw_next = ANGLE_W'(raw_sum);
		end
	end

	assign sm_bias = acc_q[AW-1] ? $signed(AW'({ALPHA_FRAC{1'b1}})) : '0;
	assign sm_full = (acc_q + sm_bias) >>> ALPHA_FRAC;
	assign ang_bias = sm_q[SMOOTH_W-1] ? $signed(SMOOTH_W'({ALPHA_FRAC{1'b1}})) : '0;
	assign ang_full = (sm_q + ang_bias) >>> ALPHA_FRAC;

	// controller state carried between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= '0;
			le_q <= '0;
			ang_q <= '0;
			sm_q <= '0;
		end else begin
			if (cmd.decide) begin
				if (inside_band) begin
					es_q <= '0;
					le_q <= '0;
				end else begin
					es_q <= es_next;
					le_q <= err_q;
				end
			end
			if (cmd.seed_en && sm_q == '0 && raw_q != '0) begin
				sm_q <= SMOOTH_W'(raw_q) <<< ALPHA_FRAC;
			end else if (cmd.smooth_en) begin
				sm_q <= SMOOTH_W'(sm_full);
			end
			if (cmd.angle_en) begin
				ang_q <= ANGLE_W'(ang_full);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		acc_q <= acc_d;
		if (cmd.load_err) begin
			err_q <= EW'(target_position) - EW'(measured_position);
		end
		if (cmd.decide) begin
			at_q <= inside_band;
			d_q <= DW'(err_q) - DW'(le_q);
		end
		if (cmd.adj_en) begin
			adj_q <= ADJ_W'(adj_full);
		end
		if (cmd.raw_en) begin
			raw_q <= raw_next;
		end
	end

	assign angle = ang_q;
	assign at_target = at_q;

endmodule

// ===== src/servo_pid_with_deadband_and_smoothing_top.sv =====
// servo_pid_with_deadband_and_smoothing_top: top level with config registers,
// sequencer, datapath and output register. Depends on spid_pkg, spid_regs,
// spid_ctrl and spid_dp.
//
// Usage:
// - input channel (in_valid/in_ready) carries target_position and
//   measured_position, signed Q11.4; a transfer happens when both are high
// - output channel (out_valid/out_ready) carries angle_cmd and at_target
// - config writes use cfg_wr_en, cfg_index and cfg_data, only while idle
// - one item is worked on at a time; the shared multiplier and the
//   accumulator are reused over a fixed sequence of steps
// - outside the deadband the PID terms, clamps, angle update and smoothing
//   filter run before the result is registered; inside the deadband the
//   sequence goes from the deadband decision straight to the result
// - the output register frees the input side: a new item is taken while the
//   last result still waits; if the receiver stalls, a finished result waits
//   in the datapath until the output register is free
// - reset clears the integral, previous error, angle and filter state and
//   loads the default gains and limits
module servo_pid_with_deadband_and_smoothing_top
	import spid_pkg::*;
#(
	parameter int POSITION_WIDTH = DEF_POSITION_WIDTH,
	parameter int COEFF_FRACTION_BITS = DEF_COEFF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [POSITION_WIDTH-1:0] target_position,
	input logic signed [POSITION_WIDTH-1:0] measured_position,
	output logic out_valid,
	input logic out_ready,
	output logic signed [ANGLE_W-1:0] angle_cmd,
	output logic at_target
);

	cfg_t cfg;
	cmd_t cmd;
	logic inside_band;
	logic out_free;
	logic signed [ANGLE_W-1:0] dp_angle;
	logic dp_at_target;
	logic out_valid_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic at_target_q;

	spid_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_wr_en),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	spid_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.inside_band(inside_band),
		.out_free(out_free),
		.cmd(cmd)
	);

	spid_dp #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.target_position(target_position),
		.measured_position(measured_position),
		.inside_band(inside_band),
		.angle(dp_angle),
		.at_target(dp_at_target)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			angle_q <= dp_angle;
			at_target_q <= dp_at_target;
		end
	end

	assign out_valid = out_valid_q;
	assign angle_cmd = angle_q;
	assign at_target = at_target_q;

	// a result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> out_free)
		else $error("result loaded over a pending transfer");

	// one item in flight: after an input transfer the block is busy
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// angle stays inside the 13-bit clamp range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_cmd != $signed({1'b1, {(ANGLE_W - 1){1'b0}}}))
		else $error("servo angle outside clamp range");

endmodule
